### rtl/bitmap_page_allocator_core_assert.svh
// Assertion macros for the bitmap page allocator checker.
// Depends on: a clock named clock and a synchronous reset named reset in the using scope.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// consequent checked in the cycle after the antecedent
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// consequent checked in the same cycle
`define BPA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### rtl/bpa_pkg.sv
// Shared types, codes and defaults for the bitmap page allocator.
// No dependencies.
package bpa_pkg;

   localparam int unsigned DEF_MAX_PAGES = 65536;
   localparam int unsigned DEF_WORD_BITS = 64;
   localparam int unsigned RESET_PAGES   = 65536;
   localparam int unsigned SEG_BITS      = 8;

   localparam int unsigned FRAME_W   = 36;
   localparam int unsigned COUNT_W   = 17;
   localparam int unsigned INDEX_W   = 16;
   localparam int unsigned CSR_IDX_W = 1;

   typedef logic [1:0]           mode_type;
   typedef logic [1:0]           status_type;
   typedef logic [FRAME_W-1:0]   frame_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [INDEX_W-1:0]   index_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam mode_type MODE_ALLOC_ONE   = 2'd0;
   localparam mode_type MODE_FREE_ONE    = 2'd1;
   localparam mode_type MODE_ALLOC_RANGE = 2'd2;
   localparam mode_type MODE_FREE_RANGE  = 2'd3;

   localparam status_type ST_OK          = 2'd0;
   localparam status_type ST_NO_SPACE    = 2'd1;
   localparam status_type ST_INVALID     = 2'd2;
   localparam status_type ST_DOUBLE_FREE = 2'd3;

   localparam csr_idx_type CSR_FIRST_FRAME = 1'b0;
   localparam csr_idx_type CSR_PAGE_COUNT  = 1'b1;

endpackage

### rtl/bitmap_page_allocator_core.sv
// Bitmap page allocator: first-fit page and run allocation over a word-wide bitmap memory.
// Depends on: bpa_pkg.
//
//  channel   ports                                  handshake
//  request   req_mode, req_frame, req_count         start & !busy
//  result    rsp_status, rsp_page_index,            rsp_strobe, one cycle, no back-pressure
//            rsp_alloc_frame, rsp_free_count
//  csr       csr_index, csr_wdata                   csr_write_en, no wait
//
// Free one reads the bitmap word, then checks and clears the page bit. Allocations read and
// scan each bitmap word in turn, then read and write back each word marked; free range reads
// and writes back each word cleared. The scan unit examines 8 bitmap bits a cycle while in its
// scan state, and the single-port bitmap memory gives one word per read. Reset and a page_count
// write taken while idle with start low run a clearing pass over all bitmap words with busy
// high. Results go out on a one-cycle strobe; the receiver cannot stall, and busy is low again in the strobe cycle.
module bitmap_page_allocator_core #(
   parameter int unsigned MAX_PAGES = bpa_pkg::DEF_MAX_PAGES,
   parameter int unsigned WORD_BITS = bpa_pkg::DEF_WORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  bpa_pkg::mode_type    req_mode,
   input  bpa_pkg::frame_type   req_frame,
   input  bpa_pkg::count_type   req_count,
   output logic                 busy,
   output logic                 rsp_strobe,
   output bpa_pkg::status_type  rsp_status,
   output bpa_pkg::index_type   rsp_page_index,
   output bpa_pkg::frame_type   rsp_alloc_frame,
   output bpa_pkg::count_type   rsp_free_count,
   input  logic                 csr_write_en,
   input  bpa_pkg::csr_idx_type csr_index,
   input  bpa_pkg::frame_type   csr_wdata
);
   import bpa_pkg::*;

   // geometry; WORD_BITS is a power of two
   localparam int WL     = $clog2(WORD_BITS);
   localparam int SL     = $clog2(SEG_BITS);
   localparam int NWORDS = (MAX_PAGES + WORD_BITS - 1) >> WL;
   localparam int WA     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int CW     = $clog2(MAX_PAGES + 1);   // counts
   localparam int PW     = CW + 1;                  // page positions and run ends
   localparam int KW     = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int NSEG   = WORD_BITS / SEG_BITS;
   localparam int SGW    = (NSEG > 1) ? $clog2(NSEG) : 1;
   localparam int XW     = FRAME_W + 2;             // range-check width

   localparam logic [WA-1:0]  WORD_LAST = WA'(NWORDS - 1);
   localparam logic [SGW-1:0] SEG_LAST  = SGW'(NSEG - 1);
   localparam logic [CW-1:0]  RST_PC    =
      CW'((RESET_PAGES > MAX_PAGES) ? MAX_PAGES : RESET_PAGES);
   localparam logic [KW-1:0]  MAX_K     = KW'(MAX_PAGES);
   localparam logic [WL:0]    WB_CLIP   = (WL+1)'(WORD_BITS);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLR   = 4'd1;
   localparam logic [3:0] S_DEC   = 4'd2;
   localparam logic [3:0] S_SRD   = 4'd3;
   localparam logic [3:0] S_SSCAN = 4'd4;
   localparam logic [3:0] S_MRD   = 4'd5;
   localparam logic [3:0] S_MWR   = 4'd6;
   localparam logic [3:0] S_FRD   = 4'd7;
   localparam logic [3:0] S_FCHK  = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [WA-1:0]        word_ff, word_in;
   logic [SGW-1:0]       seg_ff, seg_in;
   frame_type            ff_ff, ff_in;         // first_frame
   logic [CW-1:0]        pc_ff, pc_in;         // page_count
   logic [CW-1:0]        free_ff, free_in;
   mode_type             mode_ff, mode_in;
   frame_type            frame_ff, frame_in;
   logic [KW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        run_ff, run_in;
   logic [PW-1:0]        start_ff, start_in;
   logic [PW-1:0]        lo_ff, lo_in;
   logic [PW-1:0]        hi_ff, hi_in;
   logic                 set_ff, set_in;
   logic [PW-1:0]        res_ff, res_in;
   logic [WL-1:0]        bit_ff, bit_in;
   logic [WORD_BITS-1:0] rd_data_ff;

   logic                 rsp_strobe_ff;
   status_type           rsp_status_ff;
   index_type            rsp_index_ff;
   frame_type            rsp_frame_ff;
   count_type            rsp_free_ff;

   // bitmap: 1 = allocated
   logic [WORD_BITS-1:0] mem [NWORDS];
   logic                 mem_we;
   logic [WORD_BITS-1:0] mem_wdata;

   // finish of a word
   logic                 fin;
   status_type           fin_status;
   logic                 fin_alloc;
   logic [PW-1:0]        fin_idx;

   // ---------------------------------------------------------------- shared scan unit
   // one segment of SEG_BITS bitmap bits a cycle while in the scan state, carrying run length and start
   logic [SEG_BITS-1:0]  seg_bits;
   logic [PW-1:0]        seg_base;
   logic [CW-1:0]        scan_run;
   logic [PW-1:0]        scan_start;
   logic                 scan_found;

   assign seg_bits = rd_data_ff[int'(seg_ff) * SEG_BITS +: SEG_BITS];
   assign seg_base = (PW'(word_ff) << WL) + (PW'(seg_ff) << SL);

   always_comb begin
      logic [PW-1:0] idx;
      logic          taken;
      scan_run   = run_ff;
      scan_start = start_ff;
      scan_found = 1'b0;
      for (int b = 0; b < SEG_BITS; b++) begin
         idx   = seg_base + PW'(b);
         // pages past page_count count as taken
         taken = seg_bits[b] | (idx >= PW'(pc_ff));
         if (!scan_found) begin
            if (taken) begin
               scan_run = '0;
            end else begin
               if (scan_run == '0) begin
                  scan_start = idx;
               end
               scan_run = scan_run + CW'(1);
               if (KW'(scan_run) == cnt_ff) begin
                  scan_found = 1'b1;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- request decode
   logic [XW-1:0] pool_end, frame_x, diff_x, run_end_x;
   logic          frame_ge, ok_one, ok_range;
   logic [PW-1:0] req_idx;

   assign pool_end  = XW'(ff_ff) + XW'(pc_ff);
   assign frame_x   = XW'(frame_ff);
   assign diff_x    = frame_x - XW'(ff_ff);
   assign run_end_x = frame_x + XW'(cnt_ff);
   assign frame_ge  = frame_ff >= ff_ff;
   assign ok_one    = frame_ge && (frame_x < pool_end);
   assign ok_range  = (cnt_ff != '0) && frame_ge && (run_end_x <= pool_end);
   assign req_idx   = diff_x[PW-1:0];

   // ---------------------------------------------------------------- mark / clear mask
   logic [PW-1:0]        mbase, mbase_end, hi_last;
   logic [WL:0]          lo_clip, hi_clip;
   logic [WORD_BITS-1:0] ones, mask;
   logic [WA-1:0]        last_word;

   assign mbase     = PW'(word_ff) << WL;
   assign mbase_end = mbase + PW'(WORD_BITS);
   assign lo_clip   = (lo_ff <= mbase) ? '0 : (WL+1)'(lo_ff - mbase);
   assign hi_clip   = (hi_ff >= mbase_end) ? WB_CLIP : (WL+1)'(hi_ff - mbase);
   assign ones      = '1;
   assign mask      = (ones << lo_clip) & ~(ones << hi_clip);
   assign hi_last   = hi_ff - PW'(1);
   assign last_word = WA'(hi_last >> WL);

   // csr page_count, saturated
   logic [KW-1:0] csr_pc_k;
   logic [CW-1:0] csr_pc;
   assign csr_pc_k = KW'(csr_wdata[COUNT_W-1:0]);
   assign csr_pc   = (csr_pc_k > MAX_K) ? CW'(MAX_PAGES) : CW'(csr_pc_k);

   logic [KW:0]   free_sum;
   logic [PW-1:0] next_base;
   assign free_sum  = (KW+1)'(free_ff) + (KW+1)'(cnt_ff);
   assign next_base = (PW'(word_ff) + PW'(1)) << WL;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in   = state_ff;
      word_in    = word_ff;
      seg_in     = seg_ff;
      ff_in      = ff_ff;
      pc_in      = pc_ff;
      free_in    = free_ff;
      mode_in    = mode_ff;
      frame_in   = frame_ff;
      cnt_in     = cnt_ff;
      run_in     = run_ff;
      start_in   = start_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      set_in     = set_ff;
      res_in     = res_ff;
      bit_in     = bit_ff;
      mem_we     = 1'b0;
      mem_wdata  = rd_data_ff;
      fin        = 1'b0;
      fin_status = ST_OK;
      fin_alloc  = 1'b0;
      fin_idx    = '0;

      case (state_ff)
         S_IDLE: begin
            if (csr_write_en && csr_index == CSR_FIRST_FRAME) begin
               ff_in = csr_wdata;
            end
            if (start) begin
               mode_in  = req_mode;
               frame_in = req_frame;
               cnt_in   = KW'(req_count);
               state_in = S_DEC;
            end else if (csr_write_en && csr_index == CSR_PAGE_COUNT) begin
               pc_in    = csr_pc;
               free_in  = csr_pc;
               word_in  = '0;
               state_in = S_CLR;
            end
         end
         S_CLR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            if (word_ff == WORD_LAST) begin
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + WA'(1);
            end
         end
         S_DEC: begin
            run_in  = '0;
            word_in = '0;
            seg_in  = '0;
            case (mode_ff)
               MODE_ALLOC_ONE: begin
                  cnt_in = KW'(1);
                  if (free_ff == '0 || pc_ff == '0) begin
                     fin        = 1'b1;
                     fin_status = ST_NO_SPACE;
                  end else begin
                     state_in = S_SRD;
                  end
               end
               MODE_ALLOC_RANGE: begin
                  if (cnt_ff == '0 || cnt_ff > KW'(pc_ff)) begin
                     fin        = 1'b1;
                     fin_status = ST_INVALID;
                  end else if (KW'(free_ff) < cnt_ff) begin
                     fin        = 1'b1;
                     fin_status = ST_NO_SPACE;
                  end else begin
                     state_in = S_SRD;
                  end
               end
               MODE_FREE_ONE: begin
                  if (!ok_one) begin
                     fin        = 1'b1;
                     fin_status = ST_INVALID;
                  end else begin
                     res_in   = req_idx;
                     word_in  = WA'(req_idx >> WL);
                     bit_in   = req_idx[WL-1:0];
                     state_in = S_FRD;
                  end
               end
               default: begin
                  if (!ok_range) begin
                     fin        = 1'b1;
                     fin_status = ST_INVALID;
                  end else begin
                     res_in   = req_idx;
                     lo_in    = req_idx;
                     hi_in    = req_idx + PW'(cnt_ff);
                     set_in   = 1'b0;
                     word_in  = WA'(req_idx >> WL);
                     state_in = S_MRD;
                  end
               end
            endcase
         end
         S_SRD: begin
            state_in = S_SSCAN;
         end
         S_SSCAN: begin
            run_in   = scan_run;
            start_in = scan_start;
            if (scan_found) begin
               lo_in    = scan_start;
               hi_in    = scan_start + PW'(cnt_ff);
               res_in   = scan_start;
               set_in   = 1'b1;
               word_in  = WA'(scan_start >> WL);
               state_in = S_MRD;
            end else if (seg_ff == SEG_LAST) begin
               if (next_base >= PW'(pc_ff)) begin
                  fin        = 1'b1;
                  fin_status = ST_NO_SPACE;
               end else begin
                  word_in  = word_ff + WA'(1);
                  seg_in   = '0;
                  state_in = S_SRD;
               end
            end else begin
               seg_in = seg_ff + SGW'(1);
            end
         end
         S_MRD: begin
            state_in = S_MWR;
         end
         S_MWR: begin
            mem_we    = 1'b1;
            mem_wdata = set_ff ? (rd_data_ff | mask) : (rd_data_ff & ~mask);
            if (word_ff == last_word) begin
               fin     = 1'b1;
               fin_idx = res_ff;
               if (set_ff) begin
                  free_in   = free_ff - CW'(cnt_ff);
                  fin_alloc = 1'b1;
               end else begin
                  // free range saturates at page_count
                  free_in = (free_sum > (KW+1)'(pc_ff)) ? pc_ff : CW'(free_sum);
               end
            end else begin
               word_in  = word_ff + WA'(1);
               state_in = S_MRD;
            end
         end
         S_FRD: begin
            state_in = S_FCHK;
         end
         S_FCHK: begin
            fin     = 1'b1;
            fin_idx = res_ff;
            if (!rd_data_ff[bit_ff]) begin
               fin_status = ST_DOUBLE_FREE;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff & ~(WORD_BITS'(1) << bit_ff);
               free_in   = free_ff + CW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         state_in = S_IDLE;
      end
   end

   // result formatting
   logic [CW+COUNT_W-1:0] free_ext;
   logic [PW+INDEX_W-1:0] idx_ext;
   assign free_ext = {{COUNT_W{1'b0}}, free_in};
   assign idx_ext  = {{INDEX_W{1'b0}}, fin_idx};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         word_ff       <= '0;
         ff_ff         <= '0;
         pc_ff         <= RST_PC;
         free_ff       <= RST_PC;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_ff       <= word_in;
         ff_ff         <= ff_in;
         pc_ff         <= pc_in;
         free_ff       <= free_in;
         rsp_strobe_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff   <= seg_in;
      mode_ff  <= mode_in;
      frame_ff <= frame_in;
      cnt_ff   <= cnt_in;
      run_ff   <= run_in;
      start_ff <= start_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      set_ff   <= set_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      if (fin) begin
         rsp_status_ff <= fin_status;
         rsp_index_ff  <= idx_ext[INDEX_W-1:0];
         rsp_frame_ff  <= fin_alloc ? (ff_ff + FRAME_W'(fin_idx)) : '0;
         rsp_free_ff   <= free_ext[COUNT_W-1:0];
      end
   end

   // bitmap memory, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[word_ff] <= mem_wdata;
      end
      rd_data_ff <= mem[word_ff];
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_page_index  = rsp_index_ff;
   assign rsp_alloc_frame = rsp_frame_ff;
   assign rsp_free_count  = rsp_free_ff;

endmodule

### rtl/bpa_checker.sv
// Port-level checker for the bitmap page allocator, bound to the top level.
// Depends on: bpa_pkg, bitmap_page_allocator_core_assert.svh.
`include "bitmap_page_allocator_core_assert.svh"

module bpa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input bpa_pkg::status_type  rsp_status,
   input bpa_pkg::frame_type   rsp_alloc_frame,
   input logic                 csr_write_en,
   input bpa_pkg::csr_idx_type csr_index
);
   import bpa_pkg::*;

   `BPA_ASSERT_NEXT(a_strobe_pulse, rsp_strobe, !rsp_strobe, "result strobe longer than a cycle")
   `BPA_ASSERT_SAME(a_idle_on_strobe, rsp_strobe, !busy, "busy while a result word is shown")
   `BPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
   `BPA_ASSERT_SAME(a_fail_no_frame, rsp_strobe && rsp_status != ST_OK, rsp_alloc_frame == '0, "frame on failed result")
   `BPA_ASSERT_NEXT(a_resize_clears, csr_write_en && csr_index == CSR_PAGE_COUNT && !busy && !start, busy, "page_count write did not start clearing")

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (.*);

### bench/bitmap_page_allocator_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for bitmap_page_allocator_core: directed and random requests with an
// in-bench first-fit allocator predictor and an in-order result scoreboard.
// Depends on: bpa_pkg, bitmap_page_allocator_core.
module bitmap_page_allocator_core_tb;
   import bpa_pkg::*;

   localparam int unsigned POOL_MAX = 65536;
   localparam longint unsigned CYCLE_LIMIT = 20000000;

   // one expected result word
   typedef struct packed {
      status_type status;
      index_type  page_index;
      frame_type  alloc_frame;
      count_type  free_count;
   } alloc_word_type;

   // Tracks the pool as the block should see it and holds expected result words in order.
   class alloc_scoreboard_type;
      bit              page_used[POOL_MAX];
      longint unsigned free_left;
      longint unsigned base_frame;
      longint unsigned pool_pages;
      alloc_word_type  pending[$];
      int              errors;

      function void set_base_frame(frame_type v);
         base_frame = v;
      endfunction

      // a page_count write wipes the pool; oversize counts saturate
      function void set_pool_pages(longint unsigned v);
         v = v & 64'h1FFFF;
         if (v > POOL_MAX) v = POOL_MAX;
         pool_pages = v;
         foreach (page_used[i]) page_used[i] = 1'b0;
         free_left = v;
      endfunction

      function void note_request(mode_type m, frame_type f, count_type c);
         alloc_word_type  w;
         longint unsigned i, run, first, idx;
         bit              found;
         w = '0;
         found = 1'b0;
         case (m)
            MODE_ALLOC_ONE: begin
               if (free_left != 0)
                  for (i = 0; i < pool_pages; i++)
                     if (!page_used[i]) begin
                        found = 1'b1;
                        break;
                     end
               if (found) begin
                  page_used[i] = 1'b1;
                  free_left--;
                  w.page_index  = i[15:0];
                  w.alloc_frame = frame_type'(base_frame + i);
               end else
                  w.status = ST_NO_SPACE;
            end
            MODE_FREE_ONE: begin
               if (f < base_frame || f >= base_frame + pool_pages)
                  w.status = ST_INVALID;
               else begin
                  idx = f - base_frame;
                  w.page_index = idx[15:0];
                  if (!page_used[idx])
                     w.status = ST_DOUBLE_FREE;
                  else begin
                     page_used[idx] = 1'b0;
                     free_left++;
                  end
               end
            end
            MODE_ALLOC_RANGE: begin
               if (c == 0 || c > pool_pages)
                  w.status = ST_INVALID;
               else if (free_left < c)
                  w.status = ST_NO_SPACE;
               else begin
                  run = 0;
                  first = 0;
                  for (i = 0; i < pool_pages; i++) begin
                     if (page_used[i])
                        run = 0;
                     else begin
                        if (run == 0) first = i;
                        run++;
                        if (run == c) begin
                           found = 1'b1;
                           break;
                        end
                     end
                  end
                  if (found) begin
                     for (i = first; i < first + c; i++) page_used[i] = 1'b1;
                     free_left -= c;
                     w.page_index  = first[15:0];
                     w.alloc_frame = frame_type'(base_frame + first);
                  end else
                     w.status = ST_NO_SPACE;
               end
            end
            default: begin
               // free range: no per-page check, counter saturates at the pool size
               if (c == 0 || f < base_frame ||
                   longint'(f) + c > base_frame + pool_pages)
                  w.status = ST_INVALID;
               else begin
                  idx = f - base_frame;
                  for (i = idx; i < idx + c; i++) page_used[i] = 1'b0;
                  free_left += c;
                  if (free_left > pool_pages) free_left = pool_pages;
                  w.page_index = idx[15:0];
               end
            end
         endcase
         w.free_count = free_left[16:0];
         pending.push_back(w);
      endfunction

      function void check_result(alloc_word_type got);
         alloc_word_type exp;
         if (pending.size() == 0) begin
            $error("unexpected result word: %p", got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.status != exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            errors++;
         end
         if (got.page_index != exp.page_index) begin
            $error("page_index: expected %0d, got %0d", exp.page_index, got.page_index);
            errors++;
         end
         if (got.alloc_frame != exp.alloc_frame) begin
            $error("alloc_frame: expected %h, got %h", exp.alloc_frame, got.alloc_frame);
            errors++;
         end
         if (got.free_count != exp.free_count) begin
            $error("free_count: expected %0d, got %0d", exp.free_count, got.free_count);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   mode_type    req_mode = MODE_ALLOC_ONE;
   frame_type   req_frame = '0;
   count_type   req_count = '0;
   logic        busy;
   logic        rsp_strobe;
   status_type  rsp_status;
   index_type   rsp_page_index;
   frame_type   rsp_alloc_frame;
   count_type   rsp_free_count;
   logic        csr_write_en = 1'b0;
   csr_idx_type csr_index = CSR_FIRST_FRAME;
   frame_type   csr_wdata = '0;

   alloc_scoreboard_type pool_sb = new();
   bit                   idle_on;
   longint unsigned      cycles;

   always #6 clock = ~clock;

   bitmap_page_allocator_core uut (
      .clock, .reset, .start, .req_mode, .req_frame, .req_count, .busy,
      .rsp_strobe, .rsp_status, .rsp_page_index, .rsp_alloc_frame, .rsp_free_count,
      .csr_write_en, .csr_index, .csr_wdata
   );

   // result words live for one cycle only, so take every strobe
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         pool_sb.check_result({rsp_status, rsp_page_index, rsp_alloc_frame, rsp_free_count});
   end

   // watchdog: covers the clearing passes and the worst-case full-pool scans
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Present one request word and hold it until the block takes it (start & !busy).
   // start stays high afterwards; the caller lowers it on a gap or drain.
   task automatic send_request(mode_type m, frame_type f, count_type c);
      start     <= 1'b1;
      req_mode  <= m;
      req_frame <= f;
      req_count <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
      pool_sb.note_request(m, f, c);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // lower start and let every outstanding result word arrive
   task automatic drain_results();
      start <= 1'b0;
      while (pool_sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // register write; a page_count write starts a clearing pass, so wait it out
   task automatic write_csr(csr_idx_type idx, frame_type data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_FIRST_FRAME)
         pool_sb.set_base_frame(data);
      else
         pool_sb.set_pool_pages(data);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic frame_type any_frame();
      return frame_type'({$urandom, $urandom});
   endfunction

   // Mostly well-formed requests aimed inside the pool, some junk frames and counts.
   task automatic random_request();
      mode_type        m;
      frame_type       f;
      count_type       c;
      longint unsigned pages;
      int unsigned     pick;
      pages = pool_sb.pool_pages;
      pick  = $urandom_range(0, 99);
      if (pick < 32)      m = MODE_ALLOC_ONE;
      else if (pick < 57) m = MODE_FREE_ONE;
      else if (pick < 80) m = MODE_ALLOC_RANGE;
      else                m = MODE_FREE_RANGE;
      if ($urandom_range(0, 99) < 85)
         f = frame_type'(pool_sb.base_frame + $urandom_range(0, pages + 1));
      else
         f = any_frame();
      pick = $urandom_range(0, 99);
      if (pick < 80)
         c = count_type'($urandom_range(1, (pages / 4 > 1) ? pages / 4 : 1));
      else if (pick < 88)
         c = '0;
      else if (pick < 94)
         c = count_type'(pages + $urandom_range(0, 2));
      else
         c = count_type'($urandom);
      send_request(m, f, c);
   endtask

   initial begin
      frame_type   base;
      int unsigned pages;
      idle_on = 1'b0;
      cycles  = 0;
      pool_sb.set_base_frame('0);
      pool_sb.set_pool_pages(RESET_PAGES);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset pool of 65536 pages at frame 0
      send_request(MODE_ALLOC_ONE, '0, '0);
      send_request(MODE_ALLOC_ONE, '0, '0);
      send_request(MODE_FREE_ONE, 36'd0, '0);
      send_request(MODE_FREE_ONE, 36'd0, '0);           // already free
      send_request(MODE_FREE_ONE, 36'd65536, '0);       // just past the pool
      send_request(MODE_FREE_ONE, '1, '0);
      send_request(MODE_ALLOC_RANGE, '0, '0);           // zero count
      send_request(MODE_ALLOC_RANGE, '0, '1);           // larger than the pool
      send_request(MODE_ALLOC_RANGE, '0, 17'd65536);    // too few free pages
      send_request(MODE_FREE_RANGE, 36'd0, 17'd10);     // counter saturates
      send_request(MODE_ALLOC_RANGE, '0, 17'd65536);    // whole pool
      send_request(MODE_ALLOC_ONE, '0, '0);             // pool full
      send_request(MODE_FREE_RANGE, 36'd0, '0);
      send_request(MODE_FREE_RANGE, 36'd65530, 17'd7);  // runs off the end
      send_request(MODE_FREE_RANGE, 36'd0, 17'd65536);
      send_request(MODE_ALLOC_RANGE, '0, 17'd3);
      drain_results();

      // empty pool at the top of the frame space
      write_csr(CSR_FIRST_FRAME, '1);
      write_csr(CSR_PAGE_COUNT, '0);
      send_request(MODE_ALLOC_ONE, '0, '0);
      send_request(MODE_ALLOC_RANGE, '0, 17'd1);
      send_request(MODE_FREE_ONE, '1, '0);
      send_request(MODE_FREE_RANGE, '1, 17'd1);
      drain_results();

      // oversize page count saturates; frames wrap past the 36-bit top
      write_csr(CSR_FIRST_FRAME, 36'hF_FFFF_FFF0);
      write_csr(CSR_PAGE_COUNT, '1);
      send_request(MODE_ALLOC_RANGE, '0, 17'd20);
      send_request(MODE_FREE_ONE, 36'hF_FFFF_FFF3, '0);
      send_request(MODE_ALLOC_ONE, '0, '0);
      drain_results();

      // random phases over small pools; the last runs without gaps
      for (int ph = 0; ph < 12; ph++) begin
         idle_on = (ph < 11);
         case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = 36'hF_FFFF_FFFF - $urandom_range(0, 600);
            default: base = any_frame();
         endcase
         pages = (ph == 3) ? 1 : (ph == 5) ? 64 : $urandom_range(2, 400);
         write_csr(CSR_FIRST_FRAME, base);
         write_csr(CSR_PAGE_COUNT, frame_type'(pages));
         for (int n = 0; n < 160; n++) begin
            random_request();
            if (ph == 6 && n == 80) drain_results();  // hold off until all returned
         end
         drain_results();
      end

      start <= 1'b0;
      while (pool_sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (pool_sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
